// ===== rtl/bmgo_pkg.sv =====
// ----------------------------------------------------------------------------
// bmgo_pkg
// Shared types, widths and fixed-point constants of the Box-Muller grid offset
// block.
// ----------------------------------------------------------------------------
package bmgo_pkg;

    localparam int unsigned TABLE_SIDE  = 1024;
    localparam int unsigned IDX_W       = 10;
    localparam int unsigned GRID_M      = TABLE_SIDE + 1;
    localparam int unsigned M_W         = $clog2(GRID_M + 1);

    localparam int unsigned FRAC_W      = 30;
    localparam int unsigned K_W         = 5;
    localparam int unsigned LOG_W       = K_W + FRAC_W;
    localparam int unsigned LN_W        = LOG_W;
    localparam int unsigned RAD_SHIFT   = 19;
    localparam int unsigned V_W         = LN_W + RAD_SHIFT;
    localparam int unsigned SQ_W        = (V_W + 1) / 2;

    localparam int unsigned SCALE_W     = 8;
    localparam int unsigned OUT_W       = 12;
    localparam int unsigned PH_W        = 32;
    localparam int unsigned ANG_W       = 30;
    localparam int unsigned TRIG_W      = 31;
    localparam int unsigned HORNER_N    = 8;
    localparam int unsigned DIV_STEPS   = 4;

    localparam int unsigned RAD_LAT     = 1 + FRAC_W + 3 + SQ_W;
    localparam int unsigned PH_LAT      = 1 + PH_W / DIV_STEPS + 2 + 2 * HORNER_N + 1;
    localparam int unsigned SCL_LAT     = 2;

    localparam logic [FRAC_W-1:0] LN2_Q30 = 30'd744261118;
    localparam logic [ANG_W-1:0]  PI4_Q30 = 30'd843314857;
    localparam logic [TRIG_W-1:0] Q30_ONE = 31'd1 << FRAC_W;

    typedef logic [SCALE_W-1:0] scale_t;

    localparam scale_t SCALE_RESET = 8'd1;

    typedef struct packed {
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
    } grid_beat_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] x_offset;
        logic signed [OUT_W-1:0] y_offset;
    } offset_beat_t;

    typedef struct packed {
        logic [TRIG_W-1:0] trig_x;
        logic [TRIG_W-1:0] trig_y;
        logic              neg_x;
        logic              neg_y;
    } trig_t;

    // integer part, then fraction bits by repeated squaring (elaboration only)
    function automatic logic [LOG_W-1:0] log2_q30(input longint unsigned x);
        longint unsigned k;
        longint unsigned m;
        longint unsigned frac;
        k    = 0;
        frac = 0;
        for (int b = 0; b < 40; b++)
        begin
            if ((x >> (b + 1)) != 0)
            begin
                k = longint'(b + 1);
            end
        end
        m = x << (30 - k);
        for (int n = 0; n < 30; n++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (longint'(1) << 31))
            begin
                m    = m >> 1;
                frac = frac | 1;
            end
        end
        return LOG_W'((k << 30) | frac);
    endfunction

    localparam logic [LOG_W-1:0] LOG2_M = log2_q30(longint'(GRID_M));

endpackage

// ===== rtl/bmgo_chan_if.sv =====
// ----------------------------------------------------------------------------
// bmgo_chan_if
// Valid/ready channel carrying one beat of type T.
// ----------------------------------------------------------------------------
interface bmgo_chan_if #(parameter type T = logic) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/bmgo_radius.sv =====
// ----------------------------------------------------------------------------
// bmgo_radius
// Radius pipeline: log2 by squaring, ln scaling, bit-per-stage square root.
// ----------------------------------------------------------------------------
module bmgo_radius
    import bmgo_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [IDX_W-1:0] row,
    output logic [SQ_W-1:0]  radius
);

    localparam int unsigned LO_W  = 18;
    localparam int unsigned HI_W  = LOG_W - LO_W;
    localparam int unsigned SUM_W = LOG_W + FRAC_W + 1;
    localparam int unsigned SQR_W = 2 * FRAC_W + 2;
    localparam int unsigned REM_W = SQ_W + 2;

    logic [IDX_W-1:0]    row_sat;
    logic [M_W-1:0]      arg;
    logic [K_W-1:0]      k_next;
    logic [FRAC_W:0]     m_next;

    logic [K_W-1:0]      k_reg    [FRAC_W+1];
    logic [FRAC_W:0]     m_reg    [FRAC_W+1];
    logic [FRAC_W-1:0]   frac_reg [FRAC_W+1];

    logic [LOG_W-1:0]    d_reg;
    logic [LO_W+FRAC_W-1:0] pl_reg;
    logic [HI_W+FRAC_W-1:0] ph_reg;
    logic [SUM_W-1:0]    ln_sum;

    logic [REM_W-1:0]    rem_reg  [SQ_W+1];
    logic [SQ_W-1:0]     root_reg [SQ_W+1];
    logic [2*SQ_W-1:0]   vs_reg   [SQ_W+1];

    always_comb
    begin
        row_sat = row;
        if (32'(row) > TABLE_SIDE - 1)
        begin
            row_sat = IDX_W'(TABLE_SIDE - 1);
        end
        arg    = M_W'(GRID_M) - M_W'(row_sat);
        k_next = '0;
        for (int b = 0; b < M_W; b++)
        begin
            if (arg[b])
            begin
                k_next = K_W'(b);
            end
        end
        m_next = (FRAC_W + 1)'(arg) << (K_W'(FRAC_W) - k_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_reg[0]    <= k_next;
            m_reg[0]    <= m_next;
            frac_reg[0] <= '0;
        end
    end

    for (genvar n = 0; n < FRAC_W; n++)
    begin : g_log
        logic [SQR_W-1:0]  sq;
        logic [FRAC_W+1:0] sq_top;

        assign sq     = SQR_W'(m_reg[n]) * SQR_W'(m_reg[n]);
        assign sq_top = sq[SQR_W-1:FRAC_W];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                k_reg[n+1] <= k_reg[n];
                if (sq_top[FRAC_W+1])
                begin
                    m_reg[n+1]    <= sq_top[FRAC_W+1:1];
                    frac_reg[n+1] <= {frac_reg[n][FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    m_reg[n+1]    <= sq_top[FRAC_W:0];
                    frac_reg[n+1] <= {frac_reg[n][FRAC_W-2:0], 1'b0};
                end
            end
        end
    end

    // ln(M/a) = (log2 M - log2 a) * ln2, product split in two halves
    assign ln_sum = (SUM_W'(ph_reg) << LO_W) + SUM_W'(pl_reg)
                  + (SUM_W'(1) << (FRAC_W - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg       <= LOG2_M - {k_reg[FRAC_W], frac_reg[FRAC_W]};
            pl_reg      <= (LO_W + FRAC_W)'(d_reg[LO_W-1:0]) * (LO_W + FRAC_W)'(LN2_Q30);
            ph_reg      <= (HI_W + FRAC_W)'(d_reg[LOG_W-1:LO_W]) * (HI_W + FRAC_W)'(LN2_Q30);
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            vs_reg[0]   <= (2 * SQ_W)'({ln_sum[LN_W+FRAC_W-1:FRAC_W], RAD_SHIFT'(0)});
        end
    end

    for (genvar s = 0; s < SQ_W; s++)
    begin : g_sqrt
        logic [REM_W+1:0] rem2;
        logic [REM_W+1:0] trial;

        assign rem2  = {rem_reg[s], vs_reg[s][2*SQ_W-1 -: 2]};
        assign trial = (REM_W + 2)'({root_reg[s], 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vs_reg[s+1] <= vs_reg[s] << 2;
                if (rem2 >= trial)
                begin
                    rem_reg[s+1]  <= REM_W'(rem2 - trial);
                    root_reg[s+1] <= {root_reg[s][SQ_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1]  <= REM_W'(rem2);
                    root_reg[s+1] <= {root_reg[s][SQ_W-2:0], 1'b0};
                end
            end
        end
    end

    assign radius = root_reg[SQ_W];

endmodule

// ===== rtl/bmgo_phase.sv =====
// ----------------------------------------------------------------------------
// bmgo_phase
// Phase pipeline: turn fraction by long division, octant fold, Horner sin/cos.
// ----------------------------------------------------------------------------
module bmgo_phase
    import bmgo_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [IDX_W-1:0] col,
    output trig_t            trig
);

    localparam int unsigned DIV_STAGES = PH_W / DIV_STEPS;
    localparam int unsigned HP_W       = ANG_W + TRIG_W;
    localparam int unsigned AP_W       = 2 * ANG_W;
    localparam int unsigned H_STAGES   = 2 * HORNER_N;

    logic [IDX_W-1:0]  col_sat;
    logic [M_W-1:0]    prem_reg [DIV_STAGES+1];
    logic [PH_W-1:0]   quo_reg  [DIV_STAGES+1];

    logic [2:0]        oct_p;
    logic [ANG_W-1:0]  fold;
    logic [AP_W-1:0]   aprod;
    logic [AP_W-1:0]   x2prod;
    logic [ANG_W-1:0]  angl_reg;
    logic [2:0]        octl_reg;

    logic [ANG_W-1:0]  x2_reg  [H_STAGES+1];
    logic [ANG_W-1:0]  ang_reg [H_STAGES+1];
    logic [2:0]        oct_reg [H_STAGES+1];
    logic [TRIG_W-1:0] bs_reg  [HORNER_N+1];
    logic [TRIG_W-1:0] bc_reg  [HORNER_N+1];
    logic [ANG_W-1:0]  ps_reg  [HORNER_N];
    logic [ANG_W-1:0]  pc_reg  [HORNER_N];

    logic [HP_W-1:0]   snprod;
    logic [TRIG_W-1:0] sn;
    logic [TRIG_W-1:0] cs;
    logic [2:0]        oct_f;
    logic              swap;
    trig_t             trig_next;
    trig_t             trig_reg;

    always_comb
    begin
        col_sat = col;
        if (32'(col) > TABLE_SIDE - 1)
        begin
            col_sat = IDX_W'(TABLE_SIDE - 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prem_reg[0] <= M_W'(col_sat);
            quo_reg[0]  <= '0;
        end
    end

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        logic [M_W:0]           r;
        logic [DIV_STEPS-1:0]   bits;

        always_comb
        begin
            r    = {1'b0, prem_reg[g]};
            bits = '0;
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                r = {r[M_W-1:0], 1'b0};
                if (r >= (M_W + 1)'(GRID_M))
                begin
                    r = r - (M_W + 1)'(GRID_M);
                    bits[DIV_STEPS-1-s] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prem_reg[g+1] <= r[M_W-1:0];
                quo_reg[g+1]  <= {quo_reg[g][PH_W-DIV_STEPS-1:0], bits};
            end
        end
    end

    // fold into the first octant
    assign oct_p = quo_reg[DIV_STAGES][PH_W-1 -: 3];
    assign fold  = oct_p[0] ? (ANG_W'(1) << (PH_W - 3)) - ANG_W'(quo_reg[DIV_STAGES][PH_W-4:0])
                            : ANG_W'(quo_reg[DIV_STAGES][PH_W-4:0]);
    assign aprod  = AP_W'(fold) * AP_W'(PI4_Q30);
    assign x2prod = AP_W'(angl_reg) * AP_W'(angl_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angl_reg   <= aprod[ANG_W+PH_W-4:PH_W-3];
            octl_reg   <= oct_p;
            x2_reg[0]  <= x2prod[AP_W-1:FRAC_W];
            ang_reg[0] <= angl_reg;
            oct_reg[0] <= octl_reg;
            bs_reg[0]  <= Q30_ONE;
            bc_reg[0]  <= Q30_ONE;
        end
    end

    for (genvar h = 0; h < HORNER_N; h++)
    begin : g_horner
        localparam int unsigned TERM = HORNER_N - 1 - h;
        localparam int unsigned DS   = (2 * TERM + 2) * (2 * TERM + 3);
        localparam int unsigned DC   = (2 * TERM + 1) * (2 * TERM + 2);
        localparam int unsigned LS   = $clog2(DS);
        localparam int unsigned LC   = $clog2(DC);
        localparam logic [63:0] RS   = ((64'd1 << (ANG_W + LS)) + 64'(DS) - 64'd1) / 64'(DS);
        localparam logic [63:0] RC   = ((64'd1 << (ANG_W + LC)) + 64'(DC) - 64'd1) / 64'(DC);

        logic [HP_W-1:0] hs;
        logic [HP_W-1:0] hc;
        logic [HP_W:0]   qs;
        logic [HP_W:0]   qc;

        assign hs = HP_W'(x2_reg[2*h]) * HP_W'(bs_reg[h]);
        assign hc = HP_W'(x2_reg[2*h]) * HP_W'(bc_reg[h]);
        assign qs = (HP_W + 1)'(ps_reg[h]) * (HP_W + 1)'(TRIG_W'(RS));
        assign qc = (HP_W + 1)'(pc_reg[h]) * (HP_W + 1)'(TRIG_W'(RC));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ps_reg[h]      <= hs[FRAC_W+ANG_W-1:FRAC_W];
                pc_reg[h]      <= hc[FRAC_W+ANG_W-1:FRAC_W];
                x2_reg[2*h+1]  <= x2_reg[2*h];
                ang_reg[2*h+1] <= ang_reg[2*h];
                oct_reg[2*h+1] <= oct_reg[2*h];

                bs_reg[h+1]    <= Q30_ONE - TRIG_W'(qs >> (ANG_W + LS));
                bc_reg[h+1]    <= Q30_ONE - TRIG_W'(qc >> (ANG_W + LC));
                x2_reg[2*h+2]  <= x2_reg[2*h+1];
                ang_reg[2*h+2] <= ang_reg[2*h+1];
                oct_reg[2*h+2] <= oct_reg[2*h+1];
            end
        end
    end

    assign snprod = HP_W'(ang_reg[H_STAGES]) * HP_W'(bs_reg[HORNER_N]);
    assign sn     = snprod[HP_W-1:FRAC_W];
    assign cs     = bc_reg[HORNER_N];
    assign oct_f  = oct_reg[H_STAGES];
    assign swap   = oct_f[0] ^ oct_f[1];

    always_comb
    begin
        trig_next.trig_x = swap ? sn : cs;
        trig_next.trig_y = swap ? cs : sn;
        trig_next.neg_x  = oct_f[2] ^ oct_f[1];
        trig_next.neg_y  = !oct_f[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

// ===== rtl/bmgo_scale.sv =====
// ----------------------------------------------------------------------------
// bmgo_scale
// Radius times sin/cos, times scale, round half away from zero, saturate.
// ----------------------------------------------------------------------------
module bmgo_scale
    import bmgo_pkg::*;
(
    input  logic            clk,
    input  logic            en,
    input  logic [SQ_W-1:0] radius,
    input  trig_t           trig,
    input  scale_t          scale,
    output offset_beat_t    result
);

    localparam int unsigned PROD_W = SQ_W + TRIG_W;
    localparam int unsigned AMP_W  = PROD_W - 24;
    localparam int unsigned MUL_W  = SCALE_W + AMP_W + 1;
    localparam int unsigned MAG_W  = MUL_W - FRAC_W;
    localparam int unsigned POS_MAX = 2 ** (OUT_W - 1) - 1;
    localparam int unsigned NEG_MAX = 2 ** (OUT_W - 1);

    logic [PROD_W-1:0] px;
    logic [PROD_W-1:0] py;
    logic [AMP_W-1:0]  ax_reg;
    logic [AMP_W-1:0]  ay_reg;
    logic              nx_reg;
    logic              ny_reg;
    logic [MUL_W-1:0]  mx;
    logic [MUL_W-1:0]  my;
    offset_beat_t      result_next;
    offset_beat_t      result_reg;

    function automatic logic [OUT_W-1:0] to_field(input logic [MAG_W-1:0] mag,
                                                  input logic neg);
        logic [MAG_W-1:0] m;
        m = mag;
        if (neg)
        begin
            if (m > MAG_W'(NEG_MAX))
            begin
                m = MAG_W'(NEG_MAX);
            end
            return OUT_W'(0) - OUT_W'(m);
        end
        if (m > MAG_W'(POS_MAX))
        begin
            m = MAG_W'(POS_MAX);
        end
        return OUT_W'(m);
    endfunction

    assign px = PROD_W'(radius) * PROD_W'(trig.trig_x);
    assign py = PROD_W'(radius) * PROD_W'(trig.trig_y);
    assign mx = MUL_W'(scale) * MUL_W'(ax_reg) + (MUL_W'(1) << (FRAC_W - 1));
    assign my = MUL_W'(scale) * MUL_W'(ay_reg) + (MUL_W'(1) << (FRAC_W - 1));

    always_comb
    begin
        result_next.x_offset = to_field(mx[MUL_W-1:FRAC_W], nx_reg);
        result_next.y_offset = to_field(my[MUL_W-1:FRAC_W], ny_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg     <= px[PROD_W-1:24];
            ay_reg     <= py[PROD_W-1:24];
            nx_reg     <= trig.neg_x;
            ny_reg     <= trig.neg_y;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/box_muller_grid_offset.sv =====
// ----------------------------------------------------------------------------
// box_muller_grid_offset
// Maps a grid cell (row, column) to a scaled, rounded Gaussian offset pair.
// ----------------------------------------------------------------------------
// Channels: grid (sink) takes one beat per cell with row_index and col_index;
// offset (source) returns one beat per cell with x_offset and y_offset; cfg
// (sink) writes diffusion_scale, always ready; the user must write it only while
// idle, which the block does not enforce. Throughput: one beat per cycle while
// offset is not stalled. The phase path (division, octant fold, Horner sin/cos)
// is delay-matched to the radius path (30 log2 squaring stages, 27 square root
// stages, ln multiply and scaling stages).
// Reset clears all valid bits and loads diffusion_scale with 1.
// When offset is stalled the whole pipeline holds and grid.ready drops;
// bubbles keep moving, so grid.ready stays high while the output is empty.
// ----------------------------------------------------------------------------
module box_muller_grid_offset
    import bmgo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    bmgo_chan_if.sink   grid,
    bmgo_chan_if.source offset,
    bmgo_chan_if.sink   cfg
);

    localparam int unsigned LAT = RAD_LAT + SCL_LAT;
    localparam int unsigned PAD = RAD_LAT - PH_LAT;

    logic [LAT-1:0]  vld_reg;
    scale_t          scale_reg;
    logic            en;
    logic [SQ_W-1:0] radius;
    trig_t           trig_early;
    trig_t           trig_dly_reg [PAD];
    offset_beat_t    result;

    assign en           = !vld_reg[LAT-1] || offset.ready;
    assign grid.ready   = en;
    assign cfg.ready    = 1'b1;
    assign offset.valid = vld_reg[LAT-1];
    assign offset.data  = result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            scale_reg <= SCALE_RESET;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], grid.valid};
            end
            if (cfg.valid)
            begin
                scale_reg <= cfg.data;
            end
        end
    end

    bmgo_radius u_radius (
        .clk    (clk),
        .en     (en),
        .row    (grid.data.row_index),
        .radius (radius)
    );

    bmgo_phase u_phase (
        .clk  (clk),
        .en   (en),
        .col  (grid.data.col_index),
        .trig (trig_early)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_dly_reg[0] <= trig_early;
            for (int n = 1; n < PAD; n++)
            begin
                trig_dly_reg[n] <= trig_dly_reg[n-1];
            end
        end
    end

    bmgo_scale u_scale (
        .clk    (clk),
        .en     (en),
        .radius (radius),
        .trig   (trig_dly_reg[PAD-1]),
        .scale  (scale_reg),
        .result (result)
    );

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        grid.valid && grid.ready |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !offset.valid |-> grid.ready)
        else $error("input refused while output stage is empty");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        offset.valid && !offset.ready |-> !grid.ready)
        else $error("input accepted while output is stalled");

endmodule

// ===== test/tb_chan_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chan_if
// Testbench-side note: the block's own channel interface bmgo_chan_if is
// used for every channel; this file holds the shared offset-math helpers.
// ----------------------------------------------------------------------------
package tb_bmgo_math;

    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned LN2_C   = 64'd744261118;
    localparam longint unsigned PI4_C   = 64'd843314857;

    function automatic longint unsigned frac_log2(input longint unsigned x);
        longint unsigned k;
        longint unsigned m;
        longint unsigned fr;
        k  = 0;
        fr = 0;
        while (k < 40 && (x >> (k + 1)) != 0)
        begin
            k++;
        end
        m = x << (30 - k);
        for (int n = 0; n < 30; n++)
        begin
            m  = (m * m) >> 30;
            fr = fr << 1;
            if (m >= (ONE_Q30 << 1))
            begin
                m  = m >> 1;
                fr = fr | 1;
            end
        end
        return (k << 30) | fr;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v)
        begin
            bt = bt >> 2;
        end
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks box_muller_grid_offset: grid cells are streamed in, partly with random gaps,
// each offset beat is compared with a fixed-point prediction of the scaled
// Gaussian offset, across several diffusion scales and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import bmgo_pkg::*;
    import tb_bmgo_math::*;

    localparam int WATCHDOG = 20000;
    localparam int DRAIN    = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #1 clk = ~clk;

    bmgo_chan_if #(grid_beat_t)   grid_ch ();
    bmgo_chan_if #(offset_beat_t) offset_ch ();
    bmgo_chan_if #(scale_t)       cfg_ch ();

    box_muller_grid_offset dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .grid   (grid_ch.sink),
        .offset (offset_ch.source),
        .cfg    (cfg_ch.sink)
    );

    offset_beat_t pending_offsets[$];
    scale_t       scale_model;
    int           errors = 0;
    int           idle_cycles = 0;
    bit           hold_off = 1'b0;
    bit           no_stall = 1'b0;

    function automatic logic [OUT_W-1:0] round_field(longint unsigned s,
        longint unsigned trig, bit neg);
        longint unsigned mag;
        mag = (longint'(scale_model) * ((s * trig) >> 24) + (64'd1 << 29)) >> 30;
        if (mag == 0)
            return '0;
        if (neg)
        begin
            if (mag > 2048)
                mag = 2048;
            return OUT_W'(13'h1000 - mag);
        end
        if (mag > 2047)
            mag = 2047;
        return OUT_W'(mag);
    endfunction

    function automatic offset_beat_t predict_offset(grid_beat_t g);
        longint unsigned m_side, i, j, dl, l, s, p, oct, r, a, x2, bs, bc, sn, cs;
        longint unsigned cv, sv;
        bit cneg, sneg;
        offset_beat_t o;
        m_side = TABLE_SIDE + 1;
        i = g.row_index;
        j = g.col_index;
        if (i > TABLE_SIDE - 1) i = TABLE_SIDE - 1;
        if (j > TABLE_SIDE - 1) j = TABLE_SIDE - 1;
        dl = frac_log2(m_side) - frac_log2(m_side - i);
        l  = (dl * LN2_C + (64'd1 << 29)) >> 30;
        s  = root_floor((l << 1) << 18);
        p   = (j << 32) / m_side;
        oct = (p >> 29) & 7;
        r   = p & ((64'd1 << 29) - 1);
        if (oct[0]) r = (64'd1 << 29) - r;
        a  = (r * PI4_C) >> 29;
        x2 = (a * a) >> 30;
        bs = ONE_Q30;
        bc = ONE_Q30;
        for (int k = 7; k >= 0; k--)
        begin
            bs = ONE_Q30 - ((x2 * bs) >> 30) / longint'((2 * k + 2) * (2 * k + 3));
            bc = ONE_Q30 - ((x2 * bc) >> 30) / longint'((2 * k + 1) * (2 * k + 2));
        end
        sn = (a * bs) >> 30;
        cs = bc;
        case (oct)
            0: begin cv = cs; cneg = 0; sv = sn; sneg = 0; end
            1: begin cv = sn; cneg = 0; sv = cs; sneg = 0; end
            2: begin cv = sn; cneg = 1; sv = cs; sneg = 0; end
            3: begin cv = cs; cneg = 1; sv = sn; sneg = 0; end
            4: begin cv = cs; cneg = 1; sv = sn; sneg = 1; end
            5: begin cv = sn; cneg = 1; sv = cs; sneg = 1; end
            6: begin cv = sn; cneg = 0; sv = cs; sneg = 1; end
            default: begin cv = cs; cneg = 0; sv = sn; sneg = 1; end
        endcase
        o.x_offset = round_field(s, cv, cneg);
        o.y_offset = round_field(s, sv, !sneg);
        return o;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    initial
    begin
        grid_ch.valid   = 1'b0;
        grid_ch.data    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        offset_ch.ready = 1'b0;
    end

    // receiver: random stalls, always ready while no_stall is set, a forced long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            offset_ch.ready <= 1'b0;
        else if (no_stall)
            offset_ch.ready <= 1'b1;
        else
            offset_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && offset_ch.valid && offset_ch.ready)
        begin
            if (pending_offsets.size() == 0)
            begin
                $error("unexpected offset beat x=%0d y=%0d",
                       offset_ch.data.x_offset, offset_ch.data.y_offset);
                errors++;
            end
            else
            begin
                offset_beat_t e;
                e = pending_offsets.pop_front();
                if (e.x_offset !== offset_ch.data.x_offset)
                begin
                    $error("x_offset expected %0d actual %0d",
                           e.x_offset, offset_ch.data.x_offset);
                    errors++;
                end
                if (e.y_offset !== offset_ch.data.y_offset)
                begin
                    $error("y_offset expected %0d actual %0d",
                           e.y_offset, offset_ch.data.y_offset);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((grid_ch.valid && grid_ch.ready) || (offset_ch.valid && offset_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("box_muller_grid_offset: mismatch");
            $finish;
        end
    end

    task automatic send_cell(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                             input bit gaps);
        grid_beat_t g;
        int n;
        g.row_index = row;
        g.col_index = col;
        n = gaps ? gap_len() : 0;
        if (n > 0)
        begin
            grid_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        grid_ch.valid <= 1'b1;
        grid_ch.data  <= g;
        do
            @(posedge clk);
        while (!grid_ch.ready);
        pending_offsets.push_back(predict_offset(g));
    endtask

    task automatic end_burst();
        grid_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        end_burst();
        while (pending_offsets.size() != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    task automatic write_scale(input scale_t v);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        scale_model = v;
        @(posedge clk);
    endtask

    task automatic test_corners();
        logic [IDX_W-1:0] vals[6] = '{10'd0, 10'd1, 10'd512, 10'd1022, 10'd1023, 10'd256};
        no_stall = 1'b1;
        foreach (vals[a])
            foreach (vals[b])
                if (a < 4)
                    send_cell(vals[a], vals[b], 1'b0);
        // octant boundaries
        for (int k = 0; k < 8; k++)
            send_cell(10'd700, IDX_W'((k * 1025) / 8), 1'b0);
        no_stall = 1'b0;
        wait_drained();
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++)
            send_cell(IDX_W'($urandom), IDX_W'($urandom), 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 150; k++)
                send_cell(IDX_W'($urandom), IDX_W'($urandom), 1'b0);
        join
        wait_drained();
    endtask

    task automatic test_scales();
        scale_t scales[4] = '{8'd255, 8'd0, 8'd37, 8'd128};
        foreach (scales[k])
        begin
            write_scale(scales[k]);
            test_corners();
            test_random(300);
        end
    endtask

    initial
    begin
        scale_model = SCALE_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_random(300);
        test_backpressure();
        test_scales();
        wait_drained();
        if (errors == 0)
            $display("box_muller_grid_offset: match");
        else
            $display("box_muller_grid_offset: mismatch");
        $finish;
    end

endmodule
